>>> hdl/owdr_pkg.sv
// Shared constants, command codes and controller types for the omni wheel
// drive ramp. No dependencies; every other file of the block imports it.
package owdr_pkg;

  // Wheel and fixed-point geometry
  localparam int WHEELS          = 3;
  localparam int WHEEL_IDX_W     = $clog2(WHEELS);
  localparam int MAX_WHEEL_SPEED = 100;
  localparam int FRAC_BITS       = 8;
  localparam int SPD_W           = 8;
  localparam int MAG_W           = SPD_W - 1;
  localparam int TGT_W           = $clog2(MAX_WHEEL_SPEED * (1 << FRAC_BITS) + 1) + 1;
  localparam int SET_W           = 9;
  localparam int COEF_W          = 16;
  localparam int COEF_SHIFT      = 16;
  localparam int SUM_W           = SET_W + COEF_W + 3;
  localparam int ROUND_SHIFT     = COEF_SHIFT - FRAC_BITS;

  // Q0.16 coefficients: sqrt(3)/2 and 0.2 * 3.14
  localparam logic [COEF_W-1:0] COEF_SQ3_2 = 16'd56756;
  localparam logic [COEF_W-1:0] COEF_Z     = 16'd41157;

  // Speed setting
  localparam int SPEED_LIMIT = 250;
  localparam int SPEED_RESET = 20;

  // Configuration registers
  localparam int BASE_W      = 16;
  localparam int STEP_W      = 6;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int PWM_RESET   = 399;
  localparam int STEP_RESET  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_BASE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP = 4'd1;

  // Period divider: 3 quotient bits per cycle over a 24-bit dividend
  localparam int PER_W          = 23;
  localparam int PERIOD_SCALE   = 100;
  localparam int DIV_RADIX_BITS = 3;
  localparam int DIV_W          = 24;
  localparam int DIV_ITERS      = DIV_W / DIV_RADIX_BITS;
  localparam int ITER_W         = $clog2(DIV_ITERS);
  localparam int REM_W          = MAG_W + 1;

  // Command letters
  localparam logic [7:0] CMD_FWD      = 8'h41;  // 'A'
  localparam logic [7:0] CMD_BACK_L   = 8'h42;  // 'B'
  localparam logic [7:0] CMD_SIDE_L   = 8'h43;  // 'C'
  localparam logic [7:0] CMD_BACK_D   = 8'h44;  // 'D'
  localparam logic [7:0] CMD_BACK     = 8'h45;  // 'E'
  localparam logic [7:0] CMD_DIAG_F   = 8'h46;  // 'F'
  localparam logic [7:0] CMD_SIDE_R   = 8'h47;  // 'G'
  localparam logic [7:0] CMD_DIAG_H   = 8'h48;  // 'H'
  localparam logic [7:0] CMD_MODE_TGL = 8'h4C;  // 'L'
  localparam logic [7:0] CMD_SPD_UP   = 8'h58;  // 'X'
  localparam logic [7:0] CMD_SPD_DN   = 8'h59;  // 'Y'
  localparam logic [7:0] CMD_HALT     = 8'h5A;  // 'Z'

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_SUM,
    ST_RAMP,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_STORE,
    ST_OUT
  } owdr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic                   capture;
    logic                   decode;
    logic                   mul_y;
    logic                   mul_z;
    logic                   sum_en;
    logic                   ramp_en;
    logic                   div_load;
    logic                   div_step;
    logic                   div_store;
    logic                   out_load;
    logic [WHEEL_IDX_W-1:0] wheel;
  } owdr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_drive;
    logic out_busy;
  } owdr_stat_t;

endpackage

>>> hdl/owdr_if.sv
// Channel interfaces of the omni wheel drive ramp: command/tick input,
// wheel result output and configuration write. Depends on owdr_pkg.
interface owdr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] command_byte;
  modport source (output valid, kind, command_byte, input ready);
  modport sink   (input valid, kind, command_byte, output ready);
endinterface

interface owdr_out_if
  import owdr_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [SPD_W-1:0] wheel_a_speed;
  logic signed [SPD_W-1:0] wheel_b_speed;
  logic signed [SPD_W-1:0] wheel_c_speed;
  logic                    wheel_a_forward;
  logic                    wheel_b_forward;
  logic                    wheel_c_forward;
  logic [PER_W-1:0]        wheel_a_period;
  logic [PER_W-1:0]        wheel_b_period;
  logic [PER_W-1:0]        wheel_c_period;
  logic                    omni_mode_out;
  modport source (output valid, wheel_a_speed, wheel_b_speed, wheel_c_speed,
                  wheel_a_forward, wheel_b_forward, wheel_c_forward,
                  wheel_a_period, wheel_b_period, wheel_c_period, omni_mode_out,
                  input ready);
  modport sink   (input valid, wheel_a_speed, wheel_b_speed, wheel_c_speed,
                  wheel_a_forward, wheel_b_forward, wheel_c_forward,
                  wheel_a_period, wheel_b_period, wheel_c_period, omni_mode_out,
                  output ready);
endinterface

interface owdr_cfg_if
  import owdr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/owdr_ctrl.sv
// Sequencer of the omni wheel drive ramp: steps the datapath through
// command decode, kinematics and the per-wheel period division. Uses owdr_pkg.
module owdr_ctrl
  import owdr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_ready,
  input  owdr_stat_t stat,
  output owdr_cmd_t  cmd
);

  owdr_state_t            state_r, state_nxt;
  logic [WHEEL_IDX_W-1:0] wheel_r, wheel_nxt;
  logic [ITER_W-1:0]      iter_r, iter_nxt;
  logic                   iter_last;
  logic                   wheel_last;

  assign iter_last  = (iter_r == ITER_W'(DIV_ITERS - 1));
  assign wheel_last = (wheel_r == WHEEL_IDX_W'(WHEELS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = in_kind ? ST_RAMP : ST_DECODE;
      end
      ST_DECODE:    state_nxt = stat.is_drive ? ST_MUL_Y : ST_IDLE;
      ST_MUL_Y:     state_nxt = ST_MUL_Z;
      ST_MUL_Z:     state_nxt = ST_SUM;
      ST_SUM:       state_nxt = ST_IDLE;
      ST_RAMP:      state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD:  state_nxt = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (iter_last) state_nxt = ST_DIV_STORE;
      end
      ST_DIV_STORE: state_nxt = wheel_last ? ST_OUT : ST_DIV_LOAD;
      ST_OUT: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Wheel and iteration counters
  always_comb begin
    wheel_nxt = wheel_r;
    iter_nxt  = iter_r;
    case (state_r)
      ST_RAMP:      wheel_nxt = '0;
      ST_DIV_LOAD:  iter_nxt  = '0;
      ST_DIV_STEP:  iter_nxt  = iter_r + ITER_W'(1);
      ST_DIV_STORE: wheel_nxt = wheel_r + WHEEL_IDX_W'(1);
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.wheel     = wheel_r;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE:    cmd.decode    = 1'b1;
      ST_MUL_Y:     cmd.mul_y     = 1'b1;
      ST_MUL_Z:     cmd.mul_z     = 1'b1;
      ST_SUM:       cmd.sum_en    = 1'b1;
      ST_RAMP:      cmd.ramp_en   = 1'b1;
      ST_DIV_LOAD:  cmd.div_load  = 1'b1;
      ST_DIV_STEP:  cmd.div_step  = 1'b1;
      ST_DIV_STORE: cmd.div_store = 1'b1;
      ST_OUT:       cmd.out_load  = !stat.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wheel_r <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      wheel_r <= wheel_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

>>> hdl/owdr_dp.sv
// Datapath of the omni wheel drive ramp: configuration registers, command
// state, kinematics, slew limiter, period divider and output register.
// Uses owdr_pkg and the channel interfaces in owdr_if.sv.
module owdr_dp
  import owdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_kind,
  input  logic [7:0]        in_command_byte,
  input  owdr_cmd_t         cmd,
  output owdr_stat_t        stat,
  owdr_cfg_if.sink          cfg_ch,
  owdr_out_if.source        out_ch
);

  // Configuration registers
  logic [BASE_W-1:0] base_r;
  logic [STEP_W-1:0] step_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_W'(PWM_RESET);
      step_r <= STEP_W'(STEP_RESET);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PWM_BASE:   base_r <= cfg_ch.data[BASE_W-1:0];
        REG_SPEED_STEP: step_r <= cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured command byte
  logic [7:0] cmdb_r;

  always_ff @(posedge clk) begin
    if (cmd.capture && !in_kind) cmdb_r <= in_command_byte;
  end

  // Command decode: body velocity, speed setting and mode
  logic signed [SET_W-1:0] spd_r, spd_nxt;
  logic                    omni_r, omni_nxt;
  logic signed [SET_W-1:0] vx, vy, vz, neg_s;
  logic                    is_drive;
  logic signed [SET_W:0]   spd_ext, step_ext, spd_up, spd_dn;
  logic signed [SET_W-1:0] x_r, y_r, z_r;

  assign neg_s    = -spd_r;
  assign spd_ext  = (SET_W+1)'(spd_r);
  assign step_ext = $signed((SET_W+1)'(step_r));
  assign spd_up   = spd_ext + step_ext;
  assign spd_dn   = spd_ext - step_ext;

  always_comb begin
    vx       = '0;
    vy       = '0;
    vz       = '0;
    is_drive = 1'b0;
    spd_nxt  = spd_r;
    omni_nxt = omni_r;
    case (cmdb_r)
      CMD_FWD: begin
        is_drive = 1'b1;
        vy       = spd_r;
      end
      CMD_BACK: begin
        is_drive = 1'b1;
        vy       = neg_s;
      end
      CMD_SIDE_L: begin
        is_drive = 1'b1;
        if (omni_r) vx = neg_s;
        else        vz = neg_s;
      end
      CMD_SIDE_R: begin
        is_drive = 1'b1;
        if (omni_r) vx = spd_r;
        else        vz = spd_r;
      end
      CMD_DIAG_H: begin
        is_drive = omni_r;
        vx       = spd_r;
        vy       = spd_r;
      end
      CMD_BACK_L: begin
        is_drive = omni_r;
        vx       = neg_s;
        vy       = spd_r;
      end
      CMD_BACK_D: begin
        is_drive = omni_r;
        vx       = neg_s;
        vy       = neg_s;
      end
      CMD_DIAG_F: begin
        is_drive = omni_r;
        vx       = spd_r;
        vy       = neg_s;
      end
      CMD_HALT:   is_drive = 1'b1;
      CMD_SPD_UP: begin
        spd_nxt = (spd_up > (SET_W+1)'(SPEED_LIMIT)) ? SET_W'(SPEED_LIMIT)
                                                     : SET_W'(spd_up);
      end
      CMD_SPD_DN: begin
        spd_nxt = (spd_dn < -(SET_W+1)'(SPEED_LIMIT)) ? -SET_W'(SPEED_LIMIT)
                                                      : SET_W'(spd_dn);
      end
      CMD_MODE_TGL: omni_nxt = !omni_r;
      default: ;
    endcase
  end

  assign stat.is_drive = is_drive;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_r  <= SET_W'(SPEED_RESET);
      omni_r <= 1'b1;
    end else if (cmd.decode) begin
      spd_r  <= spd_nxt;
      omni_r <= omni_nxt;
    end
  end

  // Velocity operands; y is stored negated
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      x_r <= vx;
      y_r <= -vy;
      z_r <= vz;
    end
  end

  // Shared multiplier: sqrt(3)/2 * y, then 0.628 * z
  logic signed [SET_W-1:0]        mul_op;
  logic signed [COEF_W:0]         mul_coef;
  logic signed [SET_W+COEF_W:0]   mul_p;
  logic signed [SUM_W-1:0]        py_r, pz_r;

  assign mul_op   = cmd.mul_y ? y_r : z_r;
  assign mul_coef = cmd.mul_y ? $signed({1'b0, COEF_SQ3_2}) : $signed({1'b0, COEF_Z});
  assign mul_p    = mul_op * mul_coef;

  always_ff @(posedge clk) begin
    if (cmd.mul_y) py_r <= SUM_W'(mul_p);
    if (cmd.mul_z) pz_r <= SUM_W'(mul_p);
  end

  // Q.16 sum to clamped Q.FRAC_BITS target, round half up
  function automatic logic signed [TGT_W-1:0] to_tgt(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W-1:0] lim;
    lim = SUM_W'(MAX_WHEEL_SPEED * (1 << FRAC_BITS));
    r   = v + SUM_W'(1 << (ROUND_SHIFT - 1));
    q   = r >>> ROUND_SHIFT;
    if (q > lim)  q = lim;
    if (q < -lim) q = -lim;
    return TGT_W'(q);
  endfunction

  // Kinematics sums
  logic signed [SUM_W-1:0] xa, xb, sum_a, sum_b, sum_c;
  logic signed [TGT_W-1:0] tgt_r [WHEELS];

  assign xa    = SUM_W'(x_r) <<< COEF_SHIFT;
  assign xb    = -(SUM_W'(x_r) <<< (COEF_SHIFT - 1));
  assign sum_a = xa + pz_r;
  assign sum_b = xb - py_r + pz_r;
  assign sum_c = xb + py_r + pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WHEELS; i++) tgt_r[i] <= '0;
    end else if (cmd.sum_en) begin
      tgt_r[0] <= to_tgt(sum_a);
      tgt_r[1] <= to_tgt(sum_b);
      tgt_r[2] <= to_tgt(sum_c);
    end
  end

  // Slew limiter: one integer step toward the target per tick
  logic signed [SPD_W-1:0] cur_r [WHEELS];
  logic signed [SPD_W-1:0] cur_nxt [WHEELS];
  logic signed [SUM_W-1:0] cur_q, tgt_q;

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      cur_q = SUM_W'(cur_r[i]) <<< FRAC_BITS;
      tgt_q = SUM_W'(tgt_r[i]);
      if (cur_q < tgt_q)      cur_nxt[i] = cur_r[i] + SPD_W'(1);
      else if (cur_q > tgt_q) cur_nxt[i] = cur_r[i] - SPD_W'(1);
      else                    cur_nxt[i] = cur_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WHEELS; i++) cur_r[i] <= '0;
    end else if (cmd.ramp_en) begin
      for (int i = 0; i < WHEELS; i++) cur_r[i] <= cur_nxt[i];
    end
  end

  // Period dividend: base * 100
  logic [PER_W-1:0] num_r;

  always_ff @(posedge clk) begin
    if (cmd.ramp_en) num_r <= PER_W'(base_r * PERIOD_SCALE);
  end

  // Restoring divider, DIV_RADIX_BITS quotient bits per cycle
  logic [REM_W-1:0]        rem_r, rem_t, rem_sh;
  logic [DIV_W-1:0]        quo_r, quo_t;
  logic [MAG_W-1:0]        dvs_r;
  logic                    zero_r;
  logic signed [SPD_W-1:0] cur_sel;
  logic [SPD_W-1:0]        cur_abs;
  logic [PER_W-1:0]        per_r [WHEELS];

  assign cur_sel = cur_r[cmd.wheel];
  assign cur_abs = cur_sel[SPD_W-1] ? SPD_W'(-cur_sel) : SPD_W'(cur_sel);

  always_comb begin
    rem_t  = rem_r;
    quo_t  = quo_r;
    rem_sh = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      rem_sh = {rem_t[REM_W-2:0], quo_t[DIV_W-1]};
      quo_t  = {quo_t[DIV_W-2:0], 1'b0};
      if (rem_sh >= REM_W'(dvs_r)) begin
        rem_t    = rem_sh - REM_W'(dvs_r);
        quo_t[0] = 1'b1;
      end else begin
        rem_t = rem_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r  <= '0;
      quo_r  <= DIV_W'(num_r);
      dvs_r  <= cur_abs[MAG_W-1:0];
      zero_r <= (cur_abs == '0);
    end else if (cmd.div_step) begin
      rem_r <= rem_t;
      quo_r <= quo_t;
    end
    if (cmd.div_store) per_r[cmd.wheel] <= zero_r ? '0 : quo_r[PER_W-1:0];
  end

  // Output register
  logic out_valid_r;

  assign out_ch.valid  = out_valid_r;
  assign stat.out_busy = out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.wheel_a_speed   <= cur_r[0];
      out_ch.wheel_b_speed   <= cur_r[1];
      out_ch.wheel_c_speed   <= cur_r[2];
      out_ch.wheel_a_forward <= (cur_r[0] > 0);
      out_ch.wheel_b_forward <= (cur_r[1] > 0);
      out_ch.wheel_c_forward <= (cur_r[2] > 0);
      out_ch.wheel_a_period  <= per_r[0];
      out_ch.wheel_b_period  <= per_r[1];
      out_ch.wheel_c_period  <= per_r[2];
      out_ch.omni_mode_out   <= omni_r;
    end
  end

endmodule

>>> hdl/omni_wheel_drive_ramp.sv
// Omni wheel drive ramp: three-wheel omni kinematics with per-wheel slew
// limiter. Top level joining owdr_ctrl and owdr_dp. Uses owdr_pkg, owdr_if.
//
// Channels: in_ch carries a kind bit and a command byte. kind 0 is a command
// (drive target, speed up/down, omni toggle, or ignored) and gives no result;
// kind 1 is a drive tick and gives one result on out_ch: three ramped wheel
// speeds, direction bits, pulse periods and the omni mode. cfg_ch writes the
// base PWM period (index 0) and the speed step (index 1); it is always ready
// and must only be written while the block is idle.
// Sequence: a non-drive command passes through DECODE, a drive command through
// DECODE, MUL_Y, MUL_Z and SUM. A tick ramps in RAMP, then divides base*100 by
// each |speed| on one shared divider at 3 quotient bits per cycle, with DIV_LOAD,
// DIV_STEP and DIV_STORE per wheel; the result is loaded into the output register
// in OUT, and the next item is taken only once the block is back in IDLE.
// Reset (synchronous, rst_n low): targets and speeds zero, speed setting 20,
// omni mode on, registers at 399 and 10, no result pending.
// Stall: the result sits in an output register. Commands are still taken
// while it waits; a following tick finishes its division and then holds
// until the pending result transfers.
module omni_wheel_drive_ramp
  import owdr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  owdr_in_if.sink    in_ch,
  owdr_out_if.source out_ch,
  owdr_cfg_if.sink   cfg_ch
);

  owdr_cmd_t  cmd;
  owdr_stat_t stat;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer
  owdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  owdr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_ch.kind),
    .in_command_byte (in_ch.command_byte),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_ch          (cfg_ch),
    .out_ch          (out_ch)
  );

endmodule
